[src/bmf_pkg.sv]
// Package for the binary morphology filter: register indexes and pixel constants.
package bmf_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MODE        = 2'd0,
		CFG_ROW_RADIUS  = 2'd1,
		CFG_COL_RADIUS  = 2'd2,
		CFG_IMAGE_WIDTH = 2'd3
	} cfg_index_t;

	// Operation selected by the mode register
	typedef enum logic {
		MODE_ERODE  = 1'b0,
		MODE_DILATE = 1'b1
	} morph_mode_t;

	localparam logic [7:0] PIX_ZERO = 8'd0;
	localparam logic [7:0] PIX_FULL = 8'd255;

	localparam logic [10:0] WIDTH_RESET = 11'd1024;

	// Per-pixel flag pair: bit 0 = pixel is zero, bit 1 = pixel is full
	localparam int FLAG_BITS = 2;

endpackage

[src/bmf_line_store.sv]
// Line store RAM of the morphology filter with registered, write-first read.
module bmf_line_store #(
	parameter int DEPTH = 1024,
	parameter int DW    = 8,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] mem_rd_q;
	logic [DW-1:0] byp_data_q;
	logic          byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			mem_rd_q   <= mem[raddr];
			// a read that meets a write to the same entry returns the new data
			byp_q      <= we && (waddr == raddr);
			byp_data_q <= wdata;
		end
	end

	assign rdata = byp_q ? byp_data_q : mem_rd_q;

endmodule

[src/binary_morphology_filter.sv]
// Binary morphology filter top level: config, raster counters, window and result stage.
// Pipeline: an accepted pixel sits in s1, and its result moves into the output reg
//   when that reg frees up; the result beat is held there until it is taken.
// Throughput: one pixel per cycle while out_ready takes results; the line store read is
//   issued at accept; its registered data meets the pixel in s1 at the window compare.
// Reset: config returns to erosion, radius 1 by 1, width 1024; counters, valids and the
//   window registers clear. The line store RAM is not cleared; rows above the first
//   rows of a frame only feed windows that are marked not valid.
module binary_morphology_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 2,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// pixel input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pixel,
	input  logic        frame_start,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  value,
	output logic        window_valid,
	output logic [11:0] center_row,
	output logic [9:0]  center_col
);

	// Column index and width compare sizes
	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int WW      = $clog2(MAX_WIDTH + 1);
	// Row counter saturates at the lower of the height limit and the output range
	localparam int ROW_TOP = (MAX_HEIGHT - 1 > 4095) ? 4095 : MAX_HEIGHT - 1;
	localparam int RW      = $clog2(ROW_TOP + 1);
	// Window span, flag column width and line store width
	localparam int SPAN    = 2 * MAX_RADIUS + 1;
	localparam int LW      = bmf_pkg::FLAG_BITS * (SPAN - 1);
	localparam int FW      = LW + bmf_pkg::FLAG_BITS;

	// ------------------------------------------------------------------
	// Configuration registers; the port never stalls
	// ------------------------------------------------------------------
	logic        cfg_mode_q;
	logic [1:0]  cfg_row_radius_q;
	logic [1:0]  cfg_col_radius_q;
	logic [10:0] cfg_width_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q       <= bmf_pkg::MODE_ERODE;
			cfg_row_radius_q <= 2'd1;
			cfg_col_radius_q <= 2'd1;
			cfg_width_q      <= bmf_pkg::WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (bmf_pkg::cfg_index_t'(cfg_index))
				bmf_pkg::CFG_MODE:        cfg_mode_q       <= cfg_data[0];
				bmf_pkg::CFG_ROW_RADIUS:  cfg_row_radius_q <= cfg_data[1:0];
				bmf_pkg::CFG_COL_RADIUS:  cfg_col_radius_q <= cfg_data[1:0];
				bmf_pkg::CFG_IMAGE_WIDTH: cfg_width_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective settings: clamp radii and width to what the hardware holds
	logic [1:0]    rr_eff;
	logic [1:0]    cr_eff;
	logic [WW-1:0] width_eff;

	always_comb begin
		rr_eff = (int'(cfg_row_radius_q) > MAX_RADIUS) ? 2'(MAX_RADIUS) : cfg_row_radius_q;
		cr_eff = (int'(cfg_col_radius_q) > MAX_RADIUS) ? 2'(MAX_RADIUS) : cfg_col_radius_q;
		if (cfg_width_q == 11'd0) begin
			width_eff = WW'(1);
		end else if (int'(cfg_width_q) > MAX_WIDTH) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(cfg_width_q);
		end
	end

	// ------------------------------------------------------------------
	// Handshake: the whole pipe advances when the output register frees up
	// ------------------------------------------------------------------
	logic s1_valid_q;
	logic out_valid_q;
	logic advance;
	logic in_fire;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || advance;
	assign in_fire  = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Raster position of the accepted beat
	// ------------------------------------------------------------------
	logic [CW-1:0] col_count_q;
	logic [RW-1:0] row_count_q;
	logic [CW-1:0] cc_in;
	logic [RW-1:0] rc_in;
	logic [WW-1:0] cc_inc;
	logic [CW-1:0] col_next;
	logic [RW-1:0] row_next;

	always_comb begin
		rc_in = frame_start ? '0 : row_count_q;
		cc_in = frame_start ? '0 : col_count_q;
		// drop back to column zero if the width shrank under the counter
		if (WW'(cc_in) >= width_eff) begin
			cc_in = '0;
		end
		cc_inc   = WW'(cc_in) + WW'(1);
		col_next = CW'(cc_inc);
		row_next = rc_in;
		if (cc_inc >= width_eff) begin
			col_next = '0;
			if (rc_in < RW'(ROW_TOP)) begin
				row_next = rc_in + RW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (in_fire) begin
			col_count_q <= col_next;
			row_count_q <= row_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: pixel flags and position, waiting on the line store read
	// ------------------------------------------------------------------
	logic [1:0]    flags_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			flags_s1 <= {pixel == bmf_pkg::PIX_FULL, pixel == bmf_pkg::PIX_ZERO};
			col_s1   <= cc_in;
			row_s1   <= rc_in;
		end
	end

	// Line store: flag history of the rows above, one entry per column
	logic          ls_we;
	logic [LW-1:0] ls_rdata;
	logic [FW-1:0] colvec;

	assign ls_we  = s1_valid_q && advance;
	assign colvec = {ls_rdata, flags_s1};

	bmf_line_store #(
		.DEPTH (MAX_WIDTH),
		.DW    (LW),
		.AW    (CW)
	) u_line_store (
		.clk   (clk),
		.we    (ls_we),
		.waddr (col_s1),
		.wdata (colvec[LW-1:0]),
		.re    (in_fire),
		.raddr (cc_in),
		.rdata (ls_rdata)
	);

	// Window registers: flag columns of the previous pixels, newest first
	logic [FW-1:0] win_q [SPAN-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SPAN - 1; k++) begin
				win_q[k] <= '0;
			end
		end else if (ls_we) begin
			win_q[0] <= colvec;
			for (int k = 1; k < SPAN - 1; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// Window compare over the enabled rows and columns
	logic [FW-1:0] win_col;
	logic          any_zero;
	logic          any_full;
	logic          win_ok;
	logic [7:0]    value_d;
	logic [CW-1:0] ccen_d;
	logic [RW-1:0] rcen_d;

	always_comb begin
		any_zero = 1'b0;
		any_full = 1'b0;
		for (int c = 0; c < SPAN; c++) begin
			win_col = (c == 0) ? colvec : win_q[(c == 0) ? 0 : c - 1];
			if (c <= 2 * int'(cr_eff)) begin
				for (int r = 0; r < SPAN; r++) begin
					if (r <= 2 * int'(rr_eff)) begin
						any_zero = any_zero | win_col[2*r];
						any_full = any_full | win_col[2*r+1];
					end
				end
			end
		end
		win_ok = (row_s1 >= RW'({rr_eff, 1'b0})) && (col_s1 >= CW'({cr_eff, 1'b0}));
		value_d = bmf_pkg::PIX_ZERO;
		if (win_ok) begin
			if (cfg_mode_q == bmf_pkg::MODE_DILATE) begin
				value_d = any_full ? bmf_pkg::PIX_FULL : bmf_pkg::PIX_ZERO;
			end else begin
				value_d = any_zero ? bmf_pkg::PIX_ZERO : bmf_pkg::PIX_FULL;
			end
		end
		// centers saturate at zero near the top and left edges
		rcen_d = (row_s1 >= RW'(rr_eff)) ? row_s1 - RW'(rr_eff) : '0;
		ccen_d = (col_s1 >= CW'(cr_eff)) ? col_s1 - CW'(cr_eff) : '0;
	end

	// ------------------------------------------------------------------
	// Output register: hold the result until the beat is taken
	// ------------------------------------------------------------------
	logic [7:0]  value_q;
	logic        wvalid_q;
	logic [11:0] crow_q;
	logic [9:0]  ccol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ls_we) begin
			value_q  <= value_d;
			wvalid_q <= win_ok;
			crow_q   <= 12'(rcen_d);
			ccol_q   <= 10'(ccen_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign window_valid = wvalid_q;
	assign center_row   = crow_q;
	assign center_col   = ccol_q;

endmodule

[tb/sv/bmf_result_checker.sv]
// Result checker for the binary morphology filter: predicts every result beat and compares.
`timescale 1ns / 100ps

module bmf_result_checker #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 2,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  pixel,
	input  logic        frame_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  value,
	input  logic        window_valid,
	input  logic [11:0] center_row,
	input  logic [9:0]  center_col,
	output int          error_count,
	output int          pending_results
);

	localparam int SPAN      = 2 * MAX_RADIUS + 1;
	localparam int HIST_BITS = 2 * bmf_pkg::FLAG_BITS * MAX_RADIUS;
	localparam int ROW_TOP   = (MAX_HEIGHT - 1 > 4095) ? 4095 : MAX_HEIGHT - 1;

	typedef struct packed {
		logic [7:0]  value;
		logic        window_valid;
		logic [11:0] center_row;
		logic [9:0]  center_col;
	} morph_result_t;

	bmf_pkg::morph_mode_t mode_reg;
	logic [1:0]           row_rad_reg;
	logic [1:0]           col_rad_reg;
	logic [10:0]          width_reg;

	// flag pairs of the rows above, per column; and the recent flag columns
	logic [HIST_BITS-1:0] line_hist [MAX_WIDTH];
	logic [HIST_BITS+1:0] win_cols [SPAN];
	logic [11:0]          row_pos;
	logic [10:0]          col_pos;

	morph_result_t expected_results [$];
	morph_result_t predicted;
	morph_result_t oldest;

	// Advance the raster position by one pixel and work out its window result.
	task automatic filter_pixel(input logic [7:0] pix, input logic fs,
			output morph_result_t res);
		int   rr;
		int   cr;
		int   w;
		int   c;
		int   j;
		logic any_zero;
		logic any_full;
		logic in_window;
		logic [HIST_BITS+1:0] colvec;

		rr = (row_rad_reg > MAX_RADIUS) ? MAX_RADIUS : row_rad_reg;
		cr = (col_rad_reg > MAX_RADIUS) ? MAX_RADIUS : col_rad_reg;
		w  = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);

		if (fs) begin
			row_pos = '0;
			col_pos = '0;
		end
		if (col_pos >= w)
			col_pos = '0;

		colvec = {line_hist[col_pos], pix == bmf_pkg::PIX_FULL, pix == bmf_pkg::PIX_ZERO};
		line_hist[col_pos] = colvec[HIST_BITS-1:0];
		for (c = SPAN - 1; c > 0; c--)
			win_cols[c] = win_cols[c-1];
		win_cols[0] = colvec;

		in_window = (row_pos >= 2 * rr) && (col_pos >= 2 * cr);
		any_zero  = 1'b0;
		any_full  = 1'b0;
		for (c = 0; c <= 2 * cr; c++)
			for (j = 0; j <= 2 * rr; j++) begin
				any_zero |= win_cols[c][2*j];
				any_full |= win_cols[c][2*j+1];
			end

		res.window_valid = in_window;
		if (!in_window)
			res.value = bmf_pkg::PIX_ZERO;
		else if (mode_reg == bmf_pkg::MODE_DILATE)
			res.value = any_full ? bmf_pkg::PIX_FULL : bmf_pkg::PIX_ZERO;
		else
			res.value = any_zero ? bmf_pkg::PIX_ZERO : bmf_pkg::PIX_FULL;
		res.center_row = (row_pos >= rr) ? 12'(row_pos - rr) : 12'd0;
		res.center_col = (col_pos >= cr) ? 10'(col_pos - cr) : 10'd0;

		col_pos++;
		if (col_pos >= w) begin
			col_pos = '0;
			if (row_pos < ROW_TOP)
				row_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_reg    = bmf_pkg::MODE_ERODE;
			row_rad_reg = 2'd1;
			col_rad_reg = 2'd1;
			width_reg   = bmf_pkg::WIDTH_RESET;
			for (int i = 0; i < MAX_WIDTH; i++)
				line_hist[i] = '0;
			for (int i = 0; i < SPAN; i++)
				win_cols[i] = '0;
			row_pos = '0;
			col_pos = '0;
			expected_results.delete();
			error_count     = 0;
			pending_results = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (bmf_pkg::cfg_index_t'(cfg_index))
					bmf_pkg::CFG_MODE:
						mode_reg = bmf_pkg::morph_mode_t'(cfg_data[0]);
					bmf_pkg::CFG_ROW_RADIUS:  row_rad_reg = cfg_data[1:0];
					bmf_pkg::CFG_COL_RADIUS:  col_rad_reg = cfg_data[1:0];
					bmf_pkg::CFG_IMAGE_WIDTH: width_reg   = cfg_data;
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				filter_pixel(pixel, frame_start, predicted);
				expected_results.push_back(predicted);
			end

			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					if (error_count < 10)
						$display("%0t: unexpected beat: val %0d wv %0b row %0d col %0d",
							$realtime, value, window_valid, center_row, center_col);
					error_count++;
				end else begin
					oldest = expected_results.pop_front();
					if (value !== oldest.value || window_valid !== oldest.window_valid ||
							center_row !== oldest.center_row ||
							center_col !== oldest.center_col) begin
						if (error_count < 10)
							$display({"%0t: exp/act val %0d/%0d wv %0b/%0b",
								" row %0d/%0d col %0d/%0d"},
								$realtime, oldest.value, value,
								oldest.window_valid, window_valid,
								oldest.center_row, center_row,
								oldest.center_col, center_col);
						error_count++;
					end
				end
			end

			pending_results = expected_results.size();
		end
	end

endmodule

[tb/sv/binary_morphology_filter_test.sv]
// Testbench top for the binary morphology filter: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module binary_morphology_filter_test;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	bmf_pkg::cfg_index_t cfg_index;
	logic [10:0]         cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [7:0]          pixel;
	logic                frame_start;
	logic                out_valid;
	logic                out_ready;
	logic [7:0]          value;
	logic                window_valid;
	logic [11:0]         center_row;
	logic [9:0]          center_col;

	int   error_count;
	int   pending_results;
	int   pixels_sent;

	// flow-control knobs, read by the sender and by the receiver process
	logic src_idle_on;
	logic sink_idle_on;
	logic hold_phase;

	binary_morphology_filter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.value        (value),
		.window_valid (window_valid),
		.center_row   (center_row),
		.center_col   (center_col)
	);

	bmf_result_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pixel           (pixel),
		.frame_start     (frame_start),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.value           (value),
		.window_valid    (window_valid),
		.center_row      (center_row),
		.center_col      (center_col),
		.error_count     (error_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: random stalls when enabled; on the rising edge of hold_phase, hold off
	// for a long stretch so the block fills up and backs up the pixel channel.
	initial begin
		int   hold_left;
		logic hold_seen;

		out_ready = 1'b0;
		hold_left = 0;
		hold_seen = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_phase && !hold_seen)
				hold_left = 200;
			hold_seen = hold_phase;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (sink_idle_on)
				out_ready <= ($urandom_range(0, 99) >= 32);
			else
				out_ready <= 1'b1;
		end
	end

	// Mostly binary content at a chosen fill density, with some grey noise mixed in.
	function automatic logic [7:0] draw_pixel(input int pct_full);
		if ($urandom_range(0, 99) < 8)
			return 8'($urandom);
		return ($urandom_range(0, 99) < pct_full) ? bmf_pkg::PIX_FULL : bmf_pkg::PIX_ZERO;
	endfunction

	// Offer one pixel beat; hold valid and payload until it is taken. Returns at a
	// falling edge with valid still high, so back-to-back beats need no re-raise.
	task automatic send_pixel(input logic [7:0] pix, input logic fs);
		while (src_idle_on && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		pixel       <= pix;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic wait_all_results();
		while (pending_results != 0)
			@(negedge clk);
	endtask

	// Drop valid and drain every outstanding result beat.
	task automatic end_phase();
		in_valid <= 1'b0;
		@(negedge clk);
		wait_all_results();
	endtask

	task automatic write_reg(input bmf_pkg::cfg_index_t idx, input logic [10:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Write all four registers; unused upper data bits carry random junk.
	task automatic configure(input bmf_pkg::morph_mode_t m, input logic [1:0] rr,
			input logic [1:0] cr, input logic [10:0] w);
		logic [10:0] d;

		d = 11'($urandom);
		d[0] = m;
		write_reg(bmf_pkg::CFG_MODE, d);
		d = 11'($urandom);
		d[1:0] = rr;
		write_reg(bmf_pkg::CFG_ROW_RADIUS, d);
		d = 11'($urandom);
		d[1:0] = cr;
		write_reg(bmf_pkg::CFG_COL_RADIUS, d);
		write_reg(bmf_pkg::CFG_IMAGE_WIDTH, w);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stream whole frames of random content. The first frame always opens with
	// frame_start (width may have changed); later ones mostly do. Now and then a
	// frame is cut short or a stray frame_start restarts the count mid-frame.
	task automatic stream_frames(input int w, input int n_frames, input int min_h,
			input int max_h, input int pct_full);
		int   h;
		int   total;
		int   cut;
		logic fs;

		for (int f = 0; f < n_frames; f++) begin
			h     = $urandom_range(min_h, max_h);
			total = w * h;
			cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
			for (int i = 0; i < cut; i++) begin
				if (i == 0)
					fs = (f == 0) || ($urandom_range(0, 4) != 0);
				else
					fs = ($urandom_range(0, 199) == 0);
				send_pixel(draw_pixel(pct_full), fs);
			end
		end
	endtask

	initial begin
		int                   rr;
		int                   cr;
		int                   cfg_w;
		int                   w_eff;
		int                   pct;
		int                   wsel;
		bmf_pkg::morph_mode_t m;

		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = bmf_pkg::CFG_MODE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		pixel        = '0;
		frame_start  = 1'b0;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		hold_phase   = 1'b0;
		pixels_sent  = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset settings, no frame_start at all; early windows are not valid.
		send_pixel(bmf_pkg::PIX_ZERO, 1'b0);
		send_pixel(bmf_pkg::PIX_FULL, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd128, 1'b0);
		end_phase();

		// Width zero acts as one column; radius 0 makes every pixel its own window.
		configure(bmf_pkg::MODE_ERODE, 2'd0, 2'd0, 11'd0);
		send_pixel(bmf_pkg::PIX_ZERO, 1'b1);
		send_pixel(bmf_pkg::PIX_FULL, 1'b0);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd127, 1'b0);
		end_phase();

		// Row radius above the maximum saturates: five-row window in one column.
		configure(bmf_pkg::MODE_DILATE, 2'd3, 2'd0, 11'd1);
		send_pixel(bmf_pkg::PIX_FULL, 1'b1);
		repeat (5) send_pixel(bmf_pkg::PIX_ZERO, 1'b0);
		end_phase();

		// Column radius above the maximum saturates: five-wide window in one row.
		configure(bmf_pkg::MODE_DILATE, 2'd0, 2'd3, 11'd5);
		send_pixel(bmf_pkg::PIX_ZERO, 1'b1);
		repeat (3) send_pixel(bmf_pkg::PIX_ZERO, 1'b0);
		send_pixel(bmf_pkg::PIX_FULL, 1'b0);
		end_phase();

		// Backpressure: sender streams flat out while the receiver holds off.
		src_idle_on  <= 1'b0;
		sink_idle_on <= 1'b0;
		configure(bmf_pkg::MODE_ERODE, 2'd1, 2'd1, 11'd16);
		hold_phase <= 1'b1;
		stream_frames(16, 2, 8, 10, 90);
		end_phase();
		hold_phase <= 1'b0;

		// Widest image (width above the maximum saturates), no idling on either side;
		// halfway through, pause the sender until every result has come back.
		configure(bmf_pkg::MODE_DILATE, 2'd0, 2'd0, 11'd2047);
		for (int i = 0; i < 1030; i++) begin
			if (i == 517) begin
				in_valid <= 1'b0;
				@(negedge clk);
				wait_all_results();
			end
			send_pixel(draw_pixel(50), i == 0);
		end
		end_phase();

		// Tall one-column stream with the tallest window.
		src_idle_on  <= 1'b1;
		sink_idle_on <= 1'b1;
		configure(bmf_pkg::MODE_ERODE, 2'd2, 2'd0, 11'd1);
		for (int i = 0; i < 250; i++)
			send_pixel(draw_pixel(85), i == 0);
		end_phase();

		// Random settings, mostly small images of well-formed frames.
		while (pixels_sent < 1800) begin
			m     = bmf_pkg::morph_mode_t'($urandom_range(0, 1));
			rr    = $urandom_range(0, 3);
			cr    = $urandom_range(0, 3);
			wsel  = $urandom_range(0, 19);
			cfg_w = (wsel == 0) ? 0 : ((wsel < 3) ? $urandom_range(13, 64) :
				$urandom_range(1, 12));
			w_eff = (cfg_w == 0) ? 1 : cfg_w;
			case ($urandom_range(0, 2))
				0:       pct = 5;
				1:       pct = 50;
				default: pct = 95;
			endcase
			src_idle_on  <= ($urandom_range(0, 3) != 0);
			sink_idle_on <= ($urandom_range(0, 3) != 0);
			configure(m, 2'(rr), 2'(cr), 11'(cfg_w));
			stream_frames(w_eff, $urandom_range(1, 3), 1, 9, pct);
			end_phase();
		end

		// Let any stray beat surface before the verdict.
		repeat (10) @(negedge clk);
		if (error_count == 0 && pending_results == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
src/bmf_pkg.sv
src/bmf_line_store.sv
src/binary_morphology_filter.sv
tb/sv/bmf_result_checker.sv
tb/sv/binary_morphology_filter_test.sv
